>>> hdl/rbl_pkg.sv
// ----------------------------------------------------------------------------
// rbl_pkg
// Types, codes and the CRC-8 step for the record bank list store.
// ----------------------------------------------------------------------------
`default_nettype none

package rbl_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int BANKS_DEF = 2;

  localparam int REC_W     = 104;  // stamp, temperature, humidity, light, distance, kind
  localparam int CHK_W     = 8;
  localparam int ENTRY_W   = REC_W + CHK_W;
  localparam int CRC_BYTES = REC_W / 8;
  localparam int BYTE_W    = $clog2(CRC_BYTES);

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  typedef enum logic [1:0] {
    OP_SAVE   = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_MISSING  = 2'd2,
    ST_BADCHECK = 2'd3
  } status_e;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rbl_in_if.sv
// ----------------------------------------------------------------------------
// rbl_in_if
// Command channel of the record bank list store: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbl_in_if;
  logic               valid;
  logic               ready;
  rbl_pkg::op_e       op;
  logic               bank;
  logic [7:0]         position;
  logic [31:0]        stamp;
  logic signed [15:0] temperature;
  logic [15:0]        humidity;
  logic [15:0]        light;
  logic [15:0]        distance;
  logic [7:0]         record_kind;

  modport source (
    output valid, op, bank, position, stamp, temperature, humidity, light, distance,
           record_kind,
    input  ready
  );

  modport sink (
    input  valid, op, bank, position, stamp, temperature, humidity, light, distance,
           record_kind,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/rbl_out_if.sv
// ----------------------------------------------------------------------------
// rbl_out_if
// Result channel of the record bank list store: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbl_out_if;
  logic               valid;
  logic               ready;
  rbl_pkg::status_e   status;
  logic [4:0]         entry_count;
  logic [31:0]        out_stamp;
  logic signed [15:0] out_temperature;
  logic [15:0]        out_humidity;
  logic [15:0]        out_light;
  logic [15:0]        out_distance;
  logic [7:0]         out_kind;
  logic [7:0]         out_check;

  modport source (
    output valid, status, entry_count, out_stamp, out_temperature, out_humidity,
           out_light, out_distance, out_kind, out_check,
    input  ready
  );

  modport sink (
    input  valid, status, entry_count, out_stamp, out_temperature, out_humidity,
           out_light, out_distance, out_kind, out_check,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/record_bank_list_store_unit.sv
// ----------------------------------------------------------------------------
// record_bank_list_store_unit
// Banked list of sensor records in one synchronous RAM with CRC-8 checks.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one command per transaction (save, delete, read, count);
//   rsp_o returns exactly one result per command, in order.
//   Commands are taken one at a time; req_i.ready is high while the
//   sequencer is idle, also while a finished result still waits on rsp_o.
//   Steps from accepted command to result valid:
//     count only, bank full, not found : result register only
//     save                             : 13 CRC byte steps, 1 RAM write
//     read                             : RAM read, 13 CRC byte steps
//     delete at slot s, count n        : n-1-s shifted entries, each read and
//                                        written back on the RAM port
//   The byte-serial CRC unit and the single RAM port set these steps.
//   Reset clears the per-bank counts and the sequencer; the RAM is not
//   cleared, only slots below a bank's count are ever read.
//   When rsp_o stalls, the result is held and the next command waits in
//   its final step until the result transaction completes.
// ----------------------------------------------------------------------------
`default_nettype none

module record_bank_list_store_unit #(
  parameter int SLOTS = rbl_pkg::SLOTS_DEF,
  parameter int BANKS = rbl_pkg::BANKS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rbl_in_if.sink      req_i,
  rbl_out_if.source   rsp_o
);

  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int BANK_W    = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int BANK_N    = 2 ** BANK_W;
  localparam int MEM_DEPTH = BANKS * SLOTS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_SAVE_WR,
    S_RD_WAIT,
    S_RD_LOAD,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_e;

  state_e                          state_q;
  rbl_pkg::op_e                    op_q;
  logic [BANK_W-1:0]               bank_q;
  logic                            bank_ok_q;
  logic [SLOT_W-1:0]               slot_q;
  logic [CNT_W-1:0]                cnt_q [BANK_N];
  logic [rbl_pkg::REC_W-1:0]       rec_q;
  logic [rbl_pkg::CHK_W-1:0]       chk_q;
  logic [7:0]                      crc_q;
  logic [rbl_pkg::BYTE_W-1:0]      byte_q;
  rbl_pkg::status_e                status_q;
  logic                            show_q;

  logic                            rsp_valid_q;
  rbl_pkg::status_e                rsp_status_q;
  logic [4:0]                      rsp_count_q;
  logic [rbl_pkg::REC_W-1:0]       rsp_rec_q;
  logic [rbl_pkg::CHK_W-1:0]       rsp_chk_q;

  logic [rbl_pkg::ENTRY_W-1:0]     mem [MEM_DEPTH];
  logic [rbl_pkg::ENTRY_W-1:0]     mem_rdata_q;
  logic                            mem_we;
  logic                            mem_re;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [ADDR_W-1:0]               mem_raddr;
  logic [rbl_pkg::ENTRY_W-1:0]     mem_wdata;

  logic [BANK_W-1:0]               in_bank;
  logic                            in_bank_ok;
  logic [CNT_W-1:0]                in_cnt;
  logic                            in_pos_ok;
  logic [SLOT_W-1:0]               in_slot;
  logic [CNT_W-1:0]                cur_cnt;
  logic [SLOT_W-1:0]               slot_nxt;
  logic [7:0]                      crc_nxt;
  logic [ADDR_W-1:0]               bank_base;

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  assign in_bank    = BANK_W'(req_i.bank);
  assign in_bank_ok = int'(req_i.bank) < BANKS;
  assign in_cnt     = cnt_q[in_bank];
  assign in_pos_ok  = CMP_W'(req_i.position) < CMP_W'(in_cnt);
  // position 0 is the newest entry, held in the top occupied slot
  assign in_slot    = SLOT_W'(CMP_W'(in_cnt) - CMP_W'(1) - CMP_W'(req_i.position));

  assign cur_cnt    = cnt_q[bank_q];
  assign slot_nxt   = slot_q + SLOT_W'(1);
  assign crc_nxt    = rbl_pkg::crc8_byte(crc_q, rec_q[8*byte_q +: 8]);
  assign bank_base  = ADDR_W'(ADDR_W'(bank_q) * ADDR_W'(SLOTS));

  assign req_i.ready = (state_q == S_IDLE);

  // --------------------------------------------------------------------------
  // RAM port control
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = bank_base + ADDR_W'(slot_q);
    mem_raddr = bank_base + ADDR_W'(slot_q);
    mem_wdata = mem_rdata_q;
    unique case (state_q)
      S_SAVE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {chk_q, rec_q};
      end
      S_RD_WAIT: begin
        mem_re = 1'b1;
      end
      S_SH_RD: begin
        mem_re    = (CNT_W'(slot_q) + CNT_W'(1)) < cur_cnt;
        mem_raddr = bank_base + ADDR_W'(slot_nxt);
      end
      S_SH_WR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      bank_q      <= '0;
      for (int b = 0; b < BANK_N; b++) begin
        cnt_q[b] <= '0;
      end
    end else begin
      // S_DONE refills the output register itself
      if (rsp_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q      <= req_i.op;
            bank_q    <= in_bank;
            bank_ok_q <= in_bank_ok;
            show_q    <= 1'b0;
            status_q  <= rbl_pkg::ST_OK;
            rec_q     <= {req_i.record_kind, req_i.distance, req_i.light, req_i.humidity,
                          req_i.temperature, req_i.stamp};
            crc_q     <= rbl_pkg::CRC_INIT;
            byte_q    <= '0;
            state_q   <= S_DONE;
            if (!in_bank_ok) begin
              status_q <= rbl_pkg::ST_MISSING;
            end else begin
              unique case (req_i.op)
                rbl_pkg::OP_SAVE: begin
                  if (int'(in_cnt) >= SLOTS) begin
                    status_q <= rbl_pkg::ST_FULL;
                  end else begin
                    slot_q  <= SLOT_W'(in_cnt);
                    state_q <= S_CRC;
                  end
                end
                rbl_pkg::OP_DELETE: begin
                  if (!in_pos_ok) begin
                    status_q <= rbl_pkg::ST_MISSING;
                  end else begin
                    slot_q  <= in_slot;
                    state_q <= S_SH_RD;
                  end
                end
                rbl_pkg::OP_READ: begin
                  if (!in_pos_ok) begin
                    status_q <= rbl_pkg::ST_MISSING;
                  end else begin
                    slot_q  <= in_slot;
                    state_q <= S_RD_WAIT;
                  end
                end
                rbl_pkg::OP_COUNT: begin
                end
              endcase
            end
          end
        end

        S_RD_WAIT: begin
          state_q <= S_RD_LOAD;
        end

        S_RD_LOAD: begin
          rec_q   <= mem_rdata_q[rbl_pkg::REC_W-1:0];
          chk_q   <= mem_rdata_q[rbl_pkg::ENTRY_W-1:rbl_pkg::REC_W];
          state_q <= S_CRC;
        end

        S_CRC: begin
          crc_q  <= crc_nxt;
          byte_q <= byte_q + rbl_pkg::BYTE_W'(1);
          if (int'(byte_q) == rbl_pkg::CRC_BYTES - 1) begin
            if (op_q == rbl_pkg::OP_SAVE) begin
              chk_q   <= crc_nxt;
              state_q <= S_SAVE_WR;
            end else begin
              // flag only a nonzero stored check that disagrees
              if ((chk_q != 8'h00) && (chk_q != crc_nxt)) begin
                status_q <= rbl_pkg::ST_BADCHECK;
              end
              show_q  <= 1'b1;
              state_q <= S_DONE;
            end
          end
        end

        S_SAVE_WR: begin
          cnt_q[bank_q] <= cur_cnt + CNT_W'(1);
          state_q       <= S_DONE;
        end

        S_SH_RD: begin
          if ((CNT_W'(slot_q) + CNT_W'(1)) < cur_cnt) begin
            state_q <= S_SH_WR;
          end else begin
            cnt_q[bank_q] <= cur_cnt - CNT_W'(1);
            state_q       <= S_DONE;
          end
        end

        S_SH_WR: begin
          slot_q  <= slot_nxt;
          state_q <= S_SH_RD;
        end

        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            rsp_count_q  <= bank_ok_q ? 5'(cur_cnt) : 5'd0;
            rsp_rec_q    <= show_q ? rec_q : '0;
            rsp_chk_q    <= show_q ? chk_q : '0;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.entry_count     = rsp_count_q;
  assign rsp_o.out_stamp       = rsp_rec_q[31:0];
  assign rsp_o.out_temperature = $signed(rsp_rec_q[47:32]);
  assign rsp_o.out_humidity    = rsp_rec_q[63:48];
  assign rsp_o.out_light       = rsp_rec_q[79:64];
  assign rsp_o.out_distance    = rsp_rec_q[95:80];
  assign rsp_o.out_kind        = rsp_rec_q[103:96];
  assign rsp_o.out_check       = rsp_chk_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_cnt) <= SLOTS)
    else $error("bank count above slot capacity");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_SAVE_WR) || (state_q == S_SH_WR)))
    else $error("RAM write outside save or shift step");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> ((CNT_W'(slot_q) + CNT_W'(1)) < cur_cnt))
    else $error("shift source beyond occupied slots");

  a_crc_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC) |-> (int'(byte_q) < rbl_pkg::CRC_BYTES))
    else $error("CRC byte index out of record");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(rsp_valid_q) && (rsp_status_q == rbl_pkg::ST_FULL))
      |-> (rsp_count_q == 5'(SLOTS)))
    else $error("bank full reported with free slots");

endmodule

`default_nettype wire

>>> sim/tb_record_bank_list_store_unit.sv
// ----------------------------------------------------------------------------
// tb_record_bank_list_store_unit
// Self-checking bench for the record bank list store. A queue of commands
// (directed corner cases, then random save/delete/read/count traffic with
// fill and drain bursts) feeds a clocked driver; a clocked monitor checks
// every result against a bank/list predictor updated at command acceptance.
// Sender gaps and receiver stalls vary by phase, with one long result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_record_bank_list_store_unit;
  import rbl_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int BANKS       = BANKS_DEF;
  localparam int MAX_CMDS    = 2048;
  localparam int RAND_PER_PH = 257;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 60;
  localparam int LIMIT       = 600000;

  localparam int PH_STEADY    = 0;
  localparam int PH_SRC_GAPS  = 1;
  localparam int PH_SNK_STALL = 2;
  localparam int PH_BOTH      = 3;

  typedef struct {
    logic [31:0]        stamp;
    logic signed [15:0] temperature;
    logic [15:0]        humidity;
    logic [15:0]        light;
    logic [15:0]        distance;
    logic [7:0]         kind;
    logic [7:0]         check;
  } entry_t;

  typedef struct {
    op_e        op;
    logic       bank;
    logic [7:0] position;
    entry_t     rec;
  } command_t;

  typedef struct {
    command_t c;
    int       phase;
    bit       hold_rsp;
    bit       drain;
  } pending_t;

  typedef struct {
    status_e    status;
    logic [4:0] entry_count;
    entry_t     rec;
  } result_t;

  logic clk;
  logic rst_n;

  rbl_in_if  req_if ();
  rbl_out_if rsp_if ();

  record_bank_list_store_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  entry_t  bank_rows [BANKS][SLOTS];
  int      bank_fill [BANKS];
  result_t expected_results [MAX_CMDS];

  pending_t cmd_queue [$];
  int       gen_fill [BANKS];
  command_t cur_cmd;

  int n_acc     = 0;
  int n_rsp     = 0;
  int errors    = 0;
  int cycles    = 0;
  int cur_phase = PH_STEADY;
  bit hold_kick = 1'b0;
  int hold_left = 0;

  function automatic logic [7:0] entry_crc(entry_t e);
    logic [103:0] msg;
    logic [7:0]   crc;
    logic [7:0]   b;
    // byte 0 is the low byte of the stamp
    msg = {e.kind, e.distance, e.light, e.humidity, e.temperature, e.stamp};
    crc = CRC_INIT;
    for (int i = 0; i < 13; i++) begin
      b = msg[8*i +: 8];
      for (int k = 7; k >= 0; k--) begin
        if (crc[7] ^ b[k]) crc = {crc[6:0], 1'b0} ^ CRC_POLY;
        else crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  function automatic result_t apply_command(command_t c);
    result_t r;
    int      cnt;
    int      slot;
    r.status      = ST_OK;
    r.entry_count = '0;
    r.rec         = '{default: '0};
    cnt           = bank_fill[c.bank];
    case (c.op)
      OP_SAVE: begin
        if (cnt >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          bank_rows[c.bank][cnt]       = c.rec;
          bank_rows[c.bank][cnt].check = entry_crc(c.rec);
          cnt++;
        end
      end
      OP_DELETE: begin
        if (int'(c.position) >= cnt) begin
          r.status = ST_MISSING;
        end else begin
          // close the gap toward the oldest slot
          for (slot = cnt - 1 - int'(c.position); slot + 1 < cnt; slot++)
            bank_rows[c.bank][slot] = bank_rows[c.bank][slot + 1];
          cnt--;
        end
      end
      OP_READ: begin
        if (int'(c.position) >= cnt) begin
          r.status = ST_MISSING;
        end else begin
          r.rec = bank_rows[c.bank][cnt - 1 - int'(c.position)];
          if (r.rec.check != 8'h00 && r.rec.check != entry_crc(r.rec))
            r.status = ST_BADCHECK;
        end
      end
      default: ;
    endcase
    bank_fill[c.bank] = cnt;
    r.entry_count     = cnt[4:0];
    return r;
  endfunction

  function automatic int sender_idle_pct(int ph);
    case (ph)
      PH_SRC_GAPS: return 45;
      PH_BOTH:     return 21;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int ph);
    case (ph)
      PH_SNK_STALL: return 45;
      PH_BOTH:      return 21;
      default:      return 0;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    case ($urandom_range(7))
      0:       e.stamp = 32'h0000_0000;
      1:       e.stamp = 32'hFFFF_FFFF;
      default: e.stamp = $urandom;
    endcase
    e.temperature = pick16();
    e.humidity    = pick16();
    e.light       = pick16();
    e.distance    = pick16();
    e.kind        = 8'($urandom);
    e.check       = 8'h00;
    return e;
  endfunction

  function automatic entry_t make_entry(logic [31:0] st, logic [15:0] t, logic [15:0] h,
                                        logic [15:0] l, logic [15:0] d, logic [7:0] k);
    entry_t e;
    e = '{stamp: st, temperature: t, humidity: h, light: l, distance: d, kind: k,
          check: 8'h00};
    return e;
  endfunction

  // Track counts here too, so positions can aim at live entries.
  task automatic queue_cmd(op_e op, int bank, int pos, entry_t rec, int phase,
                           bit hold_rsp = 1'b0, bit drain = 1'b0);
    pending_t p;
    p.c.op       = op;
    p.c.bank     = bank[0];
    p.c.position = pos[7:0];
    p.c.rec      = rec;
    p.phase      = phase;
    p.hold_rsp   = hold_rsp;
    p.drain      = drain;
    cmd_queue.push_back(p);
    if (op == OP_SAVE && gen_fill[bank] < SLOTS) gen_fill[bank]++;
    if (op == OP_DELETE && pos < gen_fill[bank]) gen_fill[bank]--;
  endtask

  function automatic int aim_position(int bank);
    int r;
    r = $urandom_range(99);
    if (gen_fill[bank] > 0 && r < 80) return $urandom_range(gen_fill[bank] - 1, 0);
    if (r < 90) return gen_fill[bank] + $urandom_range(2);
    return $urandom_range(255);
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
      errors++;
    end
  endtask

  // Driver: hold valid until the transaction completes, then pick the next item.
  always @(posedge clk) begin : drive_req
    bit       acc_now;
    bit       go;
    bit       kick;
    pending_t nxt;
    acc_now = req_if.valid && req_if.ready;
    go      = 1'b0;
    kick    = 1'b0;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (acc_now) begin
        expected_results[n_acc] = apply_command(cur_cmd);
        n_acc <= n_acc + 1;
      end
      if (acc_now || !req_if.valid) begin
        if (cmd_queue.size() != 0) begin
          nxt = cmd_queue[0];
          go  = !(nxt.drain && (acc_now || n_acc != n_rsp))
                && ($urandom_range(99) >= sender_idle_pct(nxt.phase));
        end
        if (go) begin
          void'(cmd_queue.pop_front());
          cur_cmd = nxt.c;
          kick    = nxt.hold_rsp;
          req_if.op          <= nxt.c.op;
          req_if.bank        <= nxt.c.bank;
          req_if.position    <= nxt.c.position;
          req_if.stamp       <= nxt.c.rec.stamp;
          req_if.temperature <= nxt.c.rec.temperature;
          req_if.humidity    <= nxt.c.rec.humidity;
          req_if.light       <= nxt.c.rec.light;
          req_if.distance    <= nxt.c.rec.distance;
          req_if.record_kind <= nxt.c.rec.kind;
          cur_phase          <= nxt.phase;
        end
        req_if.valid <= go;
      end
    end
    hold_kick <= kick;
  end

  always @(posedge clk) begin : hold_count
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: check each result transaction against the oldest expectation.
  always @(posedge clk) begin : check_rsp
    result_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (n_rsp >= n_acc) begin
          $error("result transaction with no command outstanding");
          errors++;
        end else begin
          want = expected_results[n_rsp];
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
          check_field("out_stamp", want.rec.stamp, rsp_if.out_stamp);
          check_field("out_temperature", 32'(want.rec.temperature),
                      32'(rsp_if.out_temperature));
          check_field("out_humidity", 32'(want.rec.humidity), 32'(rsp_if.out_humidity));
          check_field("out_light", 32'(want.rec.light), 32'(rsp_if.out_light));
          check_field("out_distance", 32'(want.rec.distance), 32'(rsp_if.out_distance));
          check_field("out_kind", 32'(want.rec.kind), 32'(rsp_if.out_kind));
          check_field("out_check", 32'(want.rec.check), 32'(rsp_if.out_check));
          n_rsp <= n_rsp + 1;
        end
      end
      rsp_if.ready <= (hold_left == 0)
                      && ($urandom_range(99) >= receiver_stall_pct(cur_phase));
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[record_bank_list_store_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    entry_t zero_rec;
    entry_t ones_rec;
    entry_t lo_rec;
    entry_t hi_rec;
    int     total;
    int     n;
    int     bank;
    int     r;
    int     burst;
    int     op_r;
    bit     held;
    bit     drained;

    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_COUNT;
    req_if.bank        = 1'b0;
    req_if.position    = '0;
    req_if.stamp       = '0;
    req_if.temperature = '0;
    req_if.humidity    = '0;
    req_if.light       = '0;
    req_if.distance    = '0;
    req_if.record_kind = '0;
    rsp_if.ready       = 1'b0;
    held               = 1'b0;
    for (int b = 0; b < BANKS; b++) begin
      bank_fill[b] = 0;
      gen_fill[b]  = 0;
    end

    zero_rec = make_entry('0, '0, '0, '0, '0, '0);  // its check byte comes out zero
    ones_rec = make_entry('1, '1, '1, '1, '1, '1);
    lo_rec   = make_entry(32'h8000_0000, 16'h8000, 16'h8000, 16'h0001, 16'h8000, 8'h80);
    hi_rec   = make_entry(32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'hFFFE, 16'h7FFF, 8'h7F);

    // Empty banks, not found, zero check byte, middle and oldest deletes
    queue_cmd(OP_COUNT,  0, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_COUNT,  1, 255, ones_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 0,   ones_rec, PH_STEADY);
    queue_cmd(OP_DELETE, 1, 255, zero_rec, PH_STEADY);
    queue_cmd(OP_SAVE,   0, 255, zero_rec, PH_STEADY);
    queue_cmd(OP_SAVE,   0, 0,   ones_rec, PH_STEADY);
    queue_cmd(OP_SAVE,   0, 128, lo_rec,   PH_STEADY);
    queue_cmd(OP_SAVE,   1, 127, hi_rec,   PH_STEADY);
    queue_cmd(OP_READ,   0, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 1,   zero_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 2,   ones_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 3,   zero_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 255, zero_rec, PH_STEADY);
    queue_cmd(OP_READ,   1, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_DELETE, 0, 1,   zero_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_READ,   0, 1,   zero_rec, PH_STEADY);
    queue_cmd(OP_DELETE, 0, 1,   zero_rec, PH_STEADY);
    queue_cmd(OP_DELETE, 0, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_COUNT,  0, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_DELETE, 0, 0,   zero_rec, PH_STEADY);
    queue_cmd(OP_COUNT,  1, 0,   ones_rec, PH_STEADY);

    for (int ph = PH_STEADY; ph <= PH_BOTH; ph++) begin
      n       = 0;
      drained = 1'b0;
      while (n < RAND_PER_PH) begin
        bank = $urandom_range(1);
        r    = $urandom_range(99);
        if (r < 4) begin
          // fill past capacity to hit bank full
          for (int j = 0; j < SLOTS + 2; j++)
            queue_cmd(OP_SAVE, bank, $urandom_range(255), random_entry(), ph);
          n += SLOTS + 2;
        end else if (r < 7) begin
          burst = gen_fill[bank] + 1;
          for (int j = 0; j < burst; j++)
            queue_cmd(OP_DELETE, bank, aim_position(bank), random_entry(), ph);
          n += burst;
        end else begin
          op_r = $urandom_range(99);
          queue_cmd(op_r < 35 ? OP_SAVE : op_r < 55 ? OP_DELETE : op_r < 90 ? OP_READ : OP_COUNT,
                    bank, aim_position(bank), random_entry(), ph,
                    ph == PH_STEADY && n >= 100 && !held, ph != PH_STEADY && !drained);
          if (ph == PH_STEADY && n >= 100) held = 1'b1;
          drained = 1'b1;
          n++;
        end
      end
    end
    total = cmd_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (n_acc != total) @(posedge clk);
    while (n_rsp != n_acc) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[record_bank_list_store_unit] OK");
    end else begin
      $display("[record_bank_list_store_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/rbl_pkg.sv
hdl/rbl_in_if.sv
hdl/rbl_out_if.sv
hdl/record_bank_list_store_unit.sv
sim/tb_record_bank_list_store_unit.sv
